// ===== design/wbct_pkg.sv =====
package wbct_pkg;

   // Default geometry of the cache.
   localparam int SLOTS_DEFAULT      = 16;
   localparam int BLOCK_BITS_DEFAULT = 16;

   // Fixed widths of the request and response fields.
   localparam int ID_W     = 16;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;

   // Request action codes.
   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_WRITE_FAIL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_READ_FAIL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic commit;
   } wbct_cmd_type;

endpackage

// ===== design/write_back_block_cache_tags.sv =====
// A request is captured in the request register, and the parallel tag compare and state
// update are committed into the response register as soon as that register is free.
// A new request is taken only once the last one has been committed: the request register
// is followed by the parallel tag compare and state update, and a response still waiting
// in its register holds the lookup back, and with it the next request.
// Reset clears the valid bits, dirty bits, victim pointer and handshake state;
// the tag store is not cleared and is only read where its valid bit is set.
module write_back_block_cache_tags #(
   parameter int SLOTS      = wbct_pkg::SLOTS_DEFAULT,
   parameter int BLOCK_BITS = wbct_pkg::BLOCK_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [wbct_pkg::ID_W-1:0]     req_block_id,
   input  logic                          req_store_write_fails,
   input  logic                          req_store_read_fails,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [wbct_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_evict_write,
   output logic [wbct_pkg::ID_W-1:0]     rsp_evict_block,
   output logic                          rsp_fetch,
   output logic                          rsp_direct_write,
   output logic [wbct_pkg::STATUS_W-1:0] rsp_status
);

   wbct_pkg::wbct_cmd_type cmd;

   // Handshake and sequencing.
   wbct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Tags, policy state and response register.
   wbct_dpath #(
      .SLOTS      (SLOTS),
      .BLOCK_BITS (BLOCK_BITS)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_action            (req_action),
      .req_block_id          (req_block_id),
      .req_store_write_fails (req_store_write_fails),
      .req_store_read_fails  (req_store_read_fails),
      .rsp_hit               (rsp_hit),
      .rsp_slot              (rsp_slot),
      .rsp_evict_write       (rsp_evict_write),
      .rsp_evict_block       (rsp_evict_block),
      .rsp_fetch             (rsp_fetch),
      .rsp_direct_write      (rsp_direct_write),
      .rsp_status            (rsp_status)
   );

endmodule

// ===== design/wbct_ctrl.sv =====
module wbct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wbct_pkg::wbct_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOOK = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   // The response register is free when empty or when it is being taken.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.load_req = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A response only appears after a lookup cycle.
   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOK))
      else $error("response raised without a lookup");

   // A commit always returns the controller to idle with a response pending.
   a_commit_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("commit did not complete");

endmodule

// ===== design/wbct_dpath.sv =====
module wbct_dpath #(
   parameter int SLOTS      = wbct_pkg::SLOTS_DEFAULT,
   parameter int BLOCK_BITS = wbct_pkg::BLOCK_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wbct_pkg::wbct_cmd_type        cmd,
   input  logic                          req_action,
   input  logic [wbct_pkg::ID_W-1:0]     req_block_id,
   input  logic                          req_store_write_fails,
   input  logic                          req_store_read_fails,
   output logic                          rsp_hit,
   output logic [wbct_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_evict_write,
   output logic [wbct_pkg::ID_W-1:0]     rsp_evict_block,
   output logic                          rsp_fetch,
   output logic                          rsp_direct_write,
   output logic [wbct_pkg::STATUS_W-1:0] rsp_status
);

   localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SW    = (PTR_W > wbct_pkg::SLOT_W) ? PTR_W : wbct_pkg::SLOT_W;
   localparam int XW    = (BLOCK_BITS > wbct_pkg::ID_W) ? BLOCK_BITS : wbct_pkg::ID_W;

   // Captured request.
   logic                  action_ff;
   logic [BLOCK_BITS-1:0] blk_ff;
   logic                  wfail_ff;
   logic                  rfail_ff;
   logic [XW-1:0]         id_ext;

   // Cache state.
   logic [BLOCK_BITS-1:0] tag_ff [SLOTS];
   logic [SLOTS-1:0]      valid_ff;
   logic [SLOTS-1:0]      valid_in;
   logic [SLOTS-1:0]      dirty_ff;
   logic [SLOTS-1:0]      dirty_in;
   logic [PTR_W-1:0]      ptr_ff;
   logic [PTR_W-1:0]      ptr_in;

   // Lookup results.
   logic [SLOTS-1:0]      match;
   logic                  hit_any;
   logic [PTR_W-1:0]      hit_idx;
   logic                  victim_dirty;
   logic                  wb_failed;
   logic                  read_miss;
   logic                  tag_we;
   logic [XW-1:0]         victim_ext;
   logic [SW-1:0]         slot_wide;

   // Response registers.
   logic                          hit_ff;
   logic                          hit_in;
   logic [wbct_pkg::SLOT_W-1:0]   slot_ff;
   logic [wbct_pkg::SLOT_W-1:0]   slot_in;
   logic                          evw_ff;
   logic                          evw_in;
   logic [wbct_pkg::ID_W-1:0]     evb_ff;
   logic [wbct_pkg::ID_W-1:0]     evb_in;
   logic                          fetch_ff;
   logic                          fetch_in;
   logic                          direct_ff;
   logic                          direct_in;
   logic [wbct_pkg::STATUS_W-1:0] status_ff;
   logic [wbct_pkg::STATUS_W-1:0] status_in;

   assign id_ext = XW'(req_block_id);

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         blk_ff    <= id_ext[BLOCK_BITS-1:0];
         wfail_ff  <= req_store_write_fails;
         rfail_ff  <= req_store_read_fails;
      end
   end

   // Parallel tag compare. Valid tags are unique, so the index is an OR.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = valid_ff[i] && (tag_ff[i] == blk_ff);
         if (match[i]) begin
            hit_idx = hit_idx | PTR_W'(i);
         end
      end
      hit_any = |match;
   end

   // Replacement and response decisions.
   always_comb begin
      victim_dirty = valid_ff[ptr_ff] && dirty_ff[ptr_ff];
      read_miss    = !hit_any && (action_ff == wbct_pkg::ACT_READ);
      wb_failed    = victim_dirty && wfail_ff;
      victim_ext   = XW'(tag_ff[ptr_ff]);
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      ptr_in       = ptr_ff;
      tag_we       = 1'b0;
      hit_in       = hit_any;
      slot_wide    = '0;
      evw_in       = 1'b0;
      evb_in       = '0;
      fetch_in     = 1'b0;
      direct_in    = 1'b0;
      status_in    = wbct_pkg::STATUS_OK;
      if (hit_any) begin
         slot_wide = SW'(hit_idx);
         if (action_ff == wbct_pkg::ACT_WRITE) begin
            dirty_in[hit_idx] = 1'b1;
         end
      end else if (!read_miss) begin
         // Write miss goes around the cache.
         direct_in = 1'b1;
         status_in = wfail_ff ? wbct_pkg::STATUS_WRITE_FAIL : wbct_pkg::STATUS_OK;
      end else begin
         // Read miss: take the victim and advance the pointer.
         slot_wide = SW'(ptr_ff);
         ptr_in    = (ptr_ff == PTR_W'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
         if (victim_dirty) begin
            evw_in = 1'b1;
            evb_in = victim_ext[wbct_pkg::ID_W-1:0];
         end
         if (wb_failed) begin
            status_in = wbct_pkg::STATUS_WRITE_FAIL;
         end else begin
            fetch_in         = 1'b1;
            dirty_in[ptr_ff] = 1'b0;
            valid_in[ptr_ff] = !rfail_ff;
            tag_we           = !rfail_ff;
            status_in = rfail_ff ? wbct_pkg::STATUS_READ_FAIL : wbct_pkg::STATUS_OK;
         end
      end
      slot_in = slot_wide[wbct_pkg::SLOT_W-1:0];
   end

   // Tag store: one write port, no reset.
   always_ff @(posedge clock) begin
      if (cmd.commit && tag_we) begin
         tag_ff[ptr_ff] <= blk_ff;
      end
   end

   // Valid, dirty and pointer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         ptr_ff   <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         ptr_ff   <= ptr_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff    <= hit_in;
         slot_ff   <= slot_in;
         evw_ff    <= evw_in;
         evb_ff    <= evb_in;
         fetch_ff  <= fetch_in;
         direct_ff <= direct_in;
         status_ff <= status_in;
      end
   end

   assign rsp_hit          = hit_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_evict_write  = evw_ff;
   assign rsp_evict_block  = evb_ff;
   assign rsp_fetch        = fetch_ff;
   assign rsp_direct_write = direct_ff;
   assign rsp_status       = status_ff;

   // No two valid slots ever hold the same block.
   a_unique_tags: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $onehot0(match))
      else $error("duplicate valid tag");

   // Fetch and direct write exclude each other, as do a hit and an eviction.
   a_exclusive_ops: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !(fetch_ff && direct_ff) && !(hit_ff && evw_ff))
      else $error("conflicting response flags");

   // A failed write-back leaves the victim slot valid and dirty.
   a_failed_wb_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && read_miss && wb_failed) |=>
         ($past(valid_ff) == valid_ff) && ($past(dirty_ff) == dirty_ff))
      else $error("failed write-back changed the victim");

endmodule

// ===== tb/write_back_block_cache_tags_tb.sv =====
`timescale 1ns / 100ps

module write_back_block_cache_tags_tb;

   localparam int NUM_SLOTS  = wbct_pkg::SLOTS_DEFAULT;
   localparam int POOL_SIZE  = 20;
   localparam int RANDOM_REQS = 1550;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic                      action;
      logic [wbct_pkg::ID_W-1:0] block_id;
      logic                      write_fails;
      logic                      read_fails;
   } cache_req_type;

   typedef struct packed {
      logic                          hit;
      logic [wbct_pkg::SLOT_W-1:0]   slot;
      logic                          evict_write;
      logic [wbct_pkg::ID_W-1:0]     evict_block;
      logic                          fetch;
      logic                          direct_write;
      logic [wbct_pkg::STATUS_W-1:0] status;
   } cache_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_action = wbct_pkg::ACT_READ;
   logic [wbct_pkg::ID_W-1:0]     req_block_id = '0;
   logic                          req_store_write_fails = 1'b0;
   logic                          req_store_read_fails = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_hit;
   logic [wbct_pkg::SLOT_W-1:0]   rsp_slot;
   logic                          rsp_evict_write;
   logic [wbct_pkg::ID_W-1:0]     rsp_evict_block;
   logic                          rsp_fetch;
   logic                          rsp_direct_write;
   logic [wbct_pkg::STATUS_W-1:0] rsp_status;

   // Shadow copy of the cache tag state.
   logic [wbct_pkg::ID_W-1:0]   line_tag [NUM_SLOTS];
   logic                        line_valid [NUM_SLOTS];
   logic                        line_dirty [NUM_SLOTS];
   logic [wbct_pkg::SLOT_W-1:0] next_victim;

   cache_req_type pending_requests[$];
   cache_rsp_type predicted_lookups[$];
   cache_req_type current_req;
   logic       req_taken = 1'b0;
   int         accepted_reqs = 0;
   int         checked_rsps = 0;
   int         mismatch_count = 0;
   int         hold_left = 0;
   logic       hold_done = 1'b0;

   // Tallies of what the run exercised.
   int n_hits = 0, n_writebacks = 0, n_wb_fails = 0, n_fetch_fails = 0, n_direct = 0;

   wire quiet_window = (accepted_reqs >= 800) && (accepted_reqs < 1000);

   write_back_block_cache_tags dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_block_id          (req_block_id),
      .req_store_write_fails (req_store_write_fails),
      .req_store_read_fails  (req_store_read_fails),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_hit               (rsp_hit),
      .rsp_slot              (rsp_slot),
      .rsp_evict_write       (rsp_evict_write),
      .rsp_evict_block       (rsp_evict_block),
      .rsp_fetch             (rsp_fetch),
      .rsp_direct_write      (rsp_direct_write),
      .rsp_status            (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the response to one request and updates the shadow state.
   function automatic cache_rsp_type lookup_and_update(cache_req_type rq);
      cache_rsp_type               r;
      int                          found;
      logic [wbct_pkg::SLOT_W-1:0] v;
      logic                        wb_failed;
      r = '0;
      found = -1;
      wb_failed = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (found < 0 && line_valid[i] && line_tag[i] == rq.block_id) found = i;
      end
      if (found >= 0) begin
         r.hit = 1'b1;
         r.slot = found[wbct_pkg::SLOT_W-1:0];
         if (rq.action == wbct_pkg::ACT_WRITE) line_dirty[found] = 1'b1;
      end else if (rq.action == wbct_pkg::ACT_WRITE) begin
         // A write miss bypasses the cache entirely.
         r.direct_write = 1'b1;
         r.status = rq.write_fails ? wbct_pkg::STATUS_WRITE_FAIL : wbct_pkg::STATUS_OK;
      end else begin
         v = next_victim;
         next_victim = next_victim + 1'b1;
         r.slot = v;
         if (line_valid[v] && line_dirty[v]) begin
            r.evict_write = 1'b1;
            r.evict_block = line_tag[v];
            if (rq.write_fails) begin
               // The victim stays as it was when its write-back fails.
               r.status = wbct_pkg::STATUS_WRITE_FAIL;
               wb_failed = 1'b1;
            end
         end
         if (!wb_failed) begin
            r.fetch = 1'b1;
            line_valid[v] = 1'b0;
            line_dirty[v] = 1'b0;
            if (rq.read_fails) begin
               r.status = wbct_pkg::STATUS_READ_FAIL;
            end else begin
               line_tag[v] = rq.block_id;
               line_valid[v] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic queue_req(input logic act, input logic [wbct_pkg::ID_W-1:0] id,
                            input logic wf, input logic rf);
      cache_req_type rq;
      rq.action = act;
      rq.block_id = id;
      rq.write_fails = wf;
      rq.read_fails = rf;
      pending_requests.push_back(rq);
   endtask

   // Request driver: a new request or a gap is chosen only once the last one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && (quiet_window || $urandom_range(99) >= 6)) begin
            current_req = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_action <= current_req.action;
            req_block_id <= current_req.block_id;
            req_store_write_fails <= current_req.write_fails;
            req_store_read_fails <= current_req.read_fails;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side readiness, with one long hold-off to back the block up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_reqs >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_window || ($urandom_range(99) >= 6);
      end
   end

   // Monitor: checks each response against the oldest prediction, then records requests.
   always @(posedge clock) begin
      cache_rsp_type act;
      cache_rsp_type exp_rsp;
      if (reset) begin
         req_taken = 1'b0;
         next_victim = '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
         end
      end else begin
         if (rsp_valid && rsp_ready) begin
            act = {rsp_hit, rsp_slot, rsp_evict_write, rsp_evict_block, rsp_fetch,
                   rsp_direct_write, rsp_status};
            checked_rsps++;
            if (predicted_lookups.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: response with none expected: hit=%0b slot=%0d ev=%0b/%h",
                           act.hit, act.slot, act.evict_write, act.evict_block);
            end else begin
               exp_rsp = predicted_lookups.pop_front();
               if (act !== exp_rsp) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("ERROR: response %0d mismatch", checked_rsps);
                     $display("  expected hit=%0b slot=%0d ev=%0b/%h fetch=%0b dw=%0b st=%0d",
                              exp_rsp.hit, exp_rsp.slot, exp_rsp.evict_write,
                              exp_rsp.evict_block, exp_rsp.fetch, exp_rsp.direct_write,
                              exp_rsp.status);
                     $display("  actual   hit=%0b slot=%0d ev=%0b/%h fetch=%0b dw=%0b st=%0d",
                              act.hit, act.slot, act.evict_write, act.evict_block,
                              act.fetch, act.direct_write, act.status);
                  end
               end
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            exp_rsp = lookup_and_update({req_action, req_block_id, req_store_write_fails,
                                         req_store_read_fails});
            predicted_lookups.push_back(exp_rsp);
            accepted_reqs++;
            if (exp_rsp.hit) n_hits++;
            if (exp_rsp.evict_write) n_writebacks++;
            if (exp_rsp.direct_write) n_direct++;
            if (exp_rsp.evict_write && exp_rsp.status == wbct_pkg::STATUS_WRITE_FAIL)
               n_wb_fails++;
            if (exp_rsp.status == wbct_pkg::STATUS_READ_FAIL) n_fetch_fails++;
         end
      end
   end

   // Stimulus, drain and verdict.
   initial begin
      logic [wbct_pkg::ID_W-1:0] id_pool [POOL_SIZE];
      logic [wbct_pkg::ID_W-1:0] id;
      logic                      act;

      // Fill and first hits at both ends of the block range; flags that do not apply.
      queue_req(wbct_pkg::ACT_READ, 16'h0000, 1'b0, 1'b0);
      queue_req(wbct_pkg::ACT_READ, 16'hFFFF, 1'b0, 1'b0);
      queue_req(wbct_pkg::ACT_READ, 16'h0000, 1'b1, 1'b1);
      queue_req(wbct_pkg::ACT_WRITE, 16'h0000, 1'b0, 1'b0);
      queue_req(wbct_pkg::ACT_WRITE, 16'hFFFF, 1'b0, 1'b1);
      // Write misses go straight to the store, once failing.
      queue_req(wbct_pkg::ACT_WRITE, 16'h1234, 1'b0, 1'b1);
      queue_req(wbct_pkg::ACT_WRITE, 16'h1234, 1'b1, 1'b0);
      // A failed fetch leaves its slot invalid.
      queue_req(wbct_pkg::ACT_READ, 16'h5555, 1'b0, 1'b1);
      queue_req(wbct_pkg::ACT_READ, 16'h5555, 1'b0, 1'b0);
      // Fill the remaining slots so that the pointer wraps onto the dirty lines.
      for (int i = 4; i < NUM_SLOTS; i++)
         queue_req(wbct_pkg::ACT_READ, 16'(32'hA000 + i), 1'b0, 1'b0);
      // Failed write-back keeps the victim; the next read still hits it.
      queue_req(wbct_pkg::ACT_READ, 16'hAAAA, 1'b1, 1'b0);
      queue_req(wbct_pkg::ACT_READ, 16'h0000, 1'b0, 1'b0);
      // Write-back succeeds but the fetch fails.
      queue_req(wbct_pkg::ACT_READ, 16'hBBBB, 1'b0, 1'b1);
      queue_req(wbct_pkg::ACT_READ, 16'hFFFF, 1'b0, 1'b0);

      // Random part: mostly a small working set so that hits and evictions recur.
      for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if ($urandom_range(99) < 4) id_pool[$urandom_range(POOL_SIZE-1)] = 16'($urandom);
         id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_SIZE-1)]
                                        : 16'($urandom);
         act = ($urandom_range(99) < 40) ? wbct_pkg::ACT_WRITE : wbct_pkg::ACT_READ;
         queue_req(act, id, $urandom_range(99) < 15, $urandom_range(99) < 10);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid || predicted_lookups.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (predicted_lookups.size() != 0) begin
         $display("ERROR: %0d responses never arrived", predicted_lookups.size());
         mismatch_count += predicted_lookups.size();
      end
      $display("Checked %0d responses to %0d requests, %0d mismatches.",
               checked_rsps, accepted_reqs, mismatch_count);
      $display("Covered %0d hits, %0d write-backs (%0d failed), %0d failed fetches, %0d %s",
               n_hits, n_writebacks, n_wb_fails, n_fetch_fails, n_direct, "direct writes.");
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("ERROR: timeout with %0d requests pending", pending_requests.size());
      $display("Verification failed");
      $finish;
   end

endmodule
